// ===== design/robin_hood_hash_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// Robin Hood hash table assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define RHH_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("port property violated");

// next-cycle implication
`define RHH_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("port property violated");

`endif

// ===== design/rhh_pkg.sv =====
// ----------------------------------------------------------------------------
// Robin Hood hash table package
// Shared codes, beat layouts and hash helpers.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int IN_W  = 72;
    localparam int OUT_W = 64;

    localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2 = 32'h1b873593;
    localparam logic [31:0] MIX_C3 = 32'he6546b64;
    localparam logic [31:0] MIX_C4 = 32'h85ebca6b;
    localparam logic [31:0] MIX_C5 = 32'hc2b2ae35;
    localparam int MIX_ROT_K = 15;
    localparam int MIX_ROT_H = 13;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_DELETED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    localparam logic REG_HASH_SEED = 1'b0;
    localparam logic REG_SIZE_LOG2 = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] hash;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [10:0] count;
        logic        load_high;
        logic [10:0] visited;
    } res_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

    // two thirds of 2^wl, rounded down
    function automatic logic [16:0] load_limit(input logic [4:0] wl);
        case (wl)
            5'd3:    load_limit = 17'd5;
            5'd4:    load_limit = 17'd10;
            5'd5:    load_limit = 17'd21;
            5'd6:    load_limit = 17'd42;
            5'd7:    load_limit = 17'd85;
            5'd8:    load_limit = 17'd170;
            5'd9:    load_limit = 17'd341;
            5'd10:   load_limit = 17'd682;
            5'd11:   load_limit = 17'd1365;
            5'd12:   load_limit = 17'd2730;
            5'd13:   load_limit = 17'd5461;
            5'd14:   load_limit = 17'd10922;
            5'd15:   load_limit = 17'd21845;
            5'd16:   load_limit = 17'd43690;
            default: load_limit = 17'd5;
        endcase
    endfunction

endpackage

// ===== design/rhh_front.sv =====
// ----------------------------------------------------------------------------
// Robin Hood hash table front end
// Accepts operation beats and computes the seeded key hash in four stages.
// ----------------------------------------------------------------------------
module rhh_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_mode,
    input  logic [31:0]     in_key,
    input  logic [31:0]     in_value,
    input  logic [31:0]     seed,
    input  logic            hold,
    output logic            push_valid,
    input  logic            push_ready,
    output rhh_pkg::item_t  push_item
);

    logic [3:0]  v_reg;
    logic [1:0]  mode_reg  [4];
    logic [31:0] key_reg   [4];
    logic [31:0] value_reg [4];
    logic [31:0] k1_reg;
    logic [31:0] k2_reg;
    logic [31:0] h3_reg;
    logic [31:0] h4_reg;
    logic        adv;
    logic [31:0] h_a;
    logic [31:0] h_b;
    logic [31:0] h_c;
    logic [31:0] h_d;

    assign adv      = !v_reg[3] || push_ready;
    assign in_ready = adv && !hold;

    always_comb
    begin
        h_a = rhh_pkg::rotl(seed ^ k2_reg, rhh_pkg::MIX_ROT_H);
        h_b = ((h_a << 2) + h_a + rhh_pkg::MIX_C3) ^ 32'd4;
        h_c = h_b ^ (h_b >> 16);
        h_d = h3_reg ^ (h3_reg >> 13);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_valid && in_ready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_reg[0]  <= in_mode;
            key_reg[0]   <= in_key;
            value_reg[0] <= in_value;
            k1_reg       <= in_key * rhh_pkg::MIX_C1;
            for (int s = 1; s < 4; s++)
            begin
                mode_reg[s]  <= mode_reg[s-1];
                key_reg[s]   <= key_reg[s-1];
                value_reg[s] <= value_reg[s-1];
            end
            k2_reg <= rhh_pkg::rotl(k1_reg, rhh_pkg::MIX_ROT_K) * rhh_pkg::MIX_C2;
            h3_reg <= h_c * rhh_pkg::MIX_C4;
            h4_reg <= h_d * rhh_pkg::MIX_C5;
        end
    end

    assign push_valid      = v_reg[3];
    assign push_item.mode  = mode_reg[3];
    assign push_item.key   = key_reg[3];
    assign push_item.value = value_reg[3];
    assign push_item.hash  = h4_reg ^ (h4_reg >> 16);

endmodule

// ===== design/rhh_queue.sv =====
// ----------------------------------------------------------------------------
// Robin Hood hash table operation queue
// Four-entry FIFO between the hashing front end and the table engine.
// ----------------------------------------------------------------------------
module rhh_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  rhh_pkg::item_t  push_item,
    output logic            pop_valid,
    input  logic            pop,
    output rhh_pkg::item_t  pop_item
);

    rhh_pkg::item_t entry_reg [4];
    logic [1:0] wptr_reg;
    logic [1:0] rptr_reg;
    logic [2:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = fill_reg != 3'd4;
    assign pop_valid  = fill_reg != 3'd0;
    assign pop_item   = entry_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            fill_reg <= fill_reg + {2'd0, do_push} - {2'd0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/rhh_back.sv =====
// ----------------------------------------------------------------------------
// Robin Hood hash table engine
// Walks the slot memory for lookup, insert, delete and clear; holds the result.
// ----------------------------------------------------------------------------
module rhh_back
#(
    parameter int TABLE_LOG2 = 10,
    parameter int VALUE_BITS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [3:0]      size_log2,
    input  logic            q_valid,
    output logic            q_pop,
    input  rhh_pkg::item_t  q_item,
    output logic            clearing,
    output logic            res_valid,
    input  logic            res_ready,
    output rhh_pkg::res_t   res
);

    localparam int TL = TABLE_LOG2;
    localparam int SLOTS = 1 << TL;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SCAN_RD = 4'd2;
    localparam logic [3:0] S_SCAN_EV = 4'd3;
    localparam logic [3:0] S_FULL_RD = 4'd4;
    localparam logic [3:0] S_FULL_EV = 4'd5;
    localparam logic [3:0] S_WALK_RD = 4'd6;
    localparam logic [3:0] S_WALK_EV = 4'd7;
    localparam logic [3:0] S_SH_RD   = 4'd8;
    localparam logic [3:0] S_SH_EV   = 4'd9;

    typedef struct packed {
        logic                  valid;
        logic [TL-1:0]         home_ofs;
        logic [31:0]           key;
        logic [VALUE_BITS-1:0] value;
    } slot_t;

    slot_t mem [SLOTS];
    slot_t rd_reg;
    slot_t wd;
    logic [TL-1:0] wa;
    logic          we;

    logic [3:0]            state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [31:0]           key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [TL-1:0]         home_reg, home_next;
    logic [TL-1:0]         idx_reg, idx_next;
    logic [TL-1:0]         cur_reg, cur_next;
    logic [TL:0]           probe_reg, probe_next;
    logic [TL:0]           step_reg, step_next;
    logic [TL:0]           visited_reg, visited_next;
    logic [TL:0]           count_reg, count_next;
    logic                  reply_reg, reply_next;
    logic                  out_valid_reg, out_valid_next;
    rhh_pkg::res_t         out_reg, out_next;

    logic [4:0]      wl;
    logic [TL:0]     cap;
    logic [TL-1:0]   mask;
    logic [TL-1:0]   idx_inc;
    logic            last;
    logic            fin;
    logic [2:0]      fin_status;
    logic [31:0]     fin_value;
    logic [TL:0]     count_inc;
    logic [TL:0]     count_dec;

    always_comb
    begin
        if (size_log2 < 4'd3)
        begin
            wl = 5'd3;
        end
        else if ({1'b0, size_log2} > 5'(TL))
        begin
            wl = 5'(TL);
        end
        else
        begin
            wl = {1'b0, size_log2};
        end
    end

    assign cap       = (TL+1)'(1) << wl;
    assign mask      = TL'(cap - (TL+1)'(1));
    assign idx_inc   = (idx_reg + TL'(1)) & mask;
    assign last      = (step_reg + (TL+1)'(1)) == cap;
    assign count_inc = (count_reg == (TL+1)'(SLOTS)) ? count_reg : count_reg + (TL+1)'(1);
    assign count_dec = (count_reg == '0) ? count_reg : count_reg - (TL+1)'(1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[idx_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        home_next      = home_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        probe_next     = probe_reg;
        step_next      = step_reg;
        visited_next   = visited_reg;
        count_next     = count_reg;
        reply_next     = reply_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        wa             = idx_reg;
        wd             = rd_reg;
        fin            = 1'b0;
        fin_status     = rhh_pkg::ST_MISSING;
        fin_value      = '0;

        case (state_reg)
            S_CLR:
            begin
                we         = 1'b1;
                wd.valid   = 1'b0;
                count_next = '0;
                idx_next   = idx_reg + TL'(1);
                if (idx_reg == TL'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                    reply_next = 1'b0;
                    if (reply_reg)
                    begin
                        fin        = 1'b1;
                        fin_status = rhh_pkg::ST_CLEARED;
                    end
                end
            end
            S_IDLE:
            begin
                if (q_valid && (!out_valid_reg || res_ready))
                begin
                    q_pop        = 1'b1;
                    op_next      = q_item.mode;
                    key_next     = q_item.key;
                    val_next     = VALUE_BITS'(q_item.value);
                    home_next    = q_item.hash[TL-1:0] & mask;
                    idx_next     = q_item.hash[TL-1:0] & mask;
                    probe_next   = '0;
                    step_next    = '0;
                    visited_next = '0;
                    case (q_item.mode)
                        rhh_pkg::MODE_CLEAR:
                        begin
                            idx_next   = '0;
                            reply_next = 1'b1;
                            state_next = S_CLR;
                        end
                        rhh_pkg::MODE_INSERT: state_next = S_SCAN_RD;
                        default:              state_next = S_WALK_RD;
                    endcase
                end
            end
            S_SCAN_RD: state_next = S_SCAN_EV;
            S_SCAN_EV:
            begin
                if (!rd_reg.valid)
                begin
                    idx_next   = home_reg;
                    step_next  = '0;
                    state_next = S_WALK_RD;
                end
                else if (last)
                begin
                    idx_next   = home_reg;
                    step_next  = '0;
                    state_next = S_FULL_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    step_next  = step_reg + (TL+1)'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_FULL_RD: state_next = S_FULL_EV;
            S_FULL_EV:
            begin
                visited_next = visited_reg + (TL+1)'(1);
                if (rd_reg.key == key_reg)
                begin
                    we         = 1'b1;
                    wd.value   = val_reg;
                    fin        = 1'b1;
                    fin_status = rhh_pkg::ST_REPLACED;
                end
                else if (last)
                begin
                    fin        = 1'b1;
                    fin_status = rhh_pkg::ST_FULL;
                end
                else
                begin
                    idx_next   = idx_inc;
                    step_next  = step_reg + (TL+1)'(1);
                    state_next = S_FULL_RD;
                end
            end
            S_WALK_RD: state_next = S_WALK_EV;
            S_WALK_EV:
            begin
                visited_next = visited_reg + (TL+1)'(1);
                idx_next     = idx_inc;
                step_next    = step_reg + (TL+1)'(1);
                probe_next   = probe_reg + (TL+1)'(1);
                state_next   = S_WALK_RD;
                if (op_reg == rhh_pkg::MODE_INSERT)
                begin
                    if (!rd_reg.valid)
                    begin
                        we          = 1'b1;
                        wd.valid    = 1'b1;
                        wd.key      = key_reg;
                        wd.value    = val_reg;
                        wd.home_ofs = probe_reg[TL-1:0];
                        count_next  = count_inc;
                        fin         = 1'b1;
                        fin_status  = rhh_pkg::ST_INSERTED;
                    end
                    else if (rd_reg.key == key_reg)
                    begin
                        we         = 1'b1;
                        wd.value   = val_reg;
                        fin        = 1'b1;
                        fin_status = rhh_pkg::ST_REPLACED;
                    end
                    else
                    begin
                        if (probe_reg > {1'b0, rd_reg.home_ofs})
                        begin
                            we          = 1'b1;
                            wd.key      = key_reg;
                            wd.value    = val_reg;
                            wd.home_ofs = probe_reg[TL-1:0];
                            key_next    = rd_reg.key;
                            val_next    = rd_reg.value;
                            probe_next  = {1'b0, rd_reg.home_ofs} + (TL+1)'(1);
                        end
                        if (last)
                        begin
                            fin        = 1'b1;
                            fin_status = rhh_pkg::ST_FULL;
                        end
                    end
                end
                else
                begin
                    if (!rd_reg.valid)
                    begin
                        fin = 1'b1;
                    end
                    else if (rd_reg.key == key_reg)
                    begin
                        if (op_reg == rhh_pkg::MODE_DELETE)
                        begin
                            cur_next   = idx_reg;
                            step_next  = '0;
                            state_next = S_SH_RD;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            fin_status = rhh_pkg::ST_FOUND;
                            fin_value  = 32'(rd_reg.value);
                        end
                    end
                    else if ({1'b0, rd_reg.home_ofs} < probe_reg || last)
                    begin
                        fin = 1'b1;
                    end
                end
            end
            S_SH_RD:
            begin
                if (last)
                begin
                    we         = 1'b1;
                    wa         = cur_reg;
                    wd.valid   = 1'b0;
                    count_next = count_dec;
                    fin        = 1'b1;
                    fin_status = rhh_pkg::ST_DELETED;
                end
                else
                begin
                    state_next = S_SH_EV;
                end
            end
            S_SH_EV:
            begin
                we = 1'b1;
                wa = cur_reg;
                if (!rd_reg.valid || rd_reg.home_ofs == '0)
                begin
                    wd.valid   = 1'b0;
                    count_next = count_dec;
                    fin        = 1'b1;
                    fin_status = rhh_pkg::ST_DELETED;
                end
                else
                begin
                    wd.home_ofs = rd_reg.home_ofs - TL'(1);
                    cur_next    = idx_reg;
                    idx_next    = idx_inc;
                    step_next   = step_reg + (TL+1)'(1);
                    state_next  = S_SH_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (fin)
        begin
            if (state_reg != S_CLR)
            begin
                state_next = S_IDLE;
            end
            out_valid_next    = 1'b1;
            out_next.status   = fin_status;
            out_next.value    = fin_value;
            out_next.count    = 11'(count_next);
            out_next.load_high = 17'(count_next) >= rhh_pkg::load_limit(wl);
            out_next.visited  = (fin_status == rhh_pkg::ST_CLEARED) ? 11'd0 : 11'(visited_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            idx_reg       <= '0;
            count_reg     <= '0;
            reply_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            reply_reg     <= reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        home_reg    <= home_next;
        cur_reg     <= cur_next;
        probe_reg   <= probe_next;
        step_reg    <= step_next;
        visited_reg <= visited_next;
        out_reg     <= out_next;
    end

    assign clearing  = state_reg == S_CLR;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ===== design/robin_hood_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// Robin Hood hash table
// Open-addressed key/value table with Robin Hood insert and backward-shift
// delete, keyed by a seeded 32-bit mix hash.
//
// Channel   Direction   Payload
// s_axis    in          mode, key, value_in
// m_axis    out         status, value_out, entry_count, load_high, slots_visited
// cfg       in          hash_seed (index 0), size_log2 (index 1)
//
// Hashing is a registered pipeline ahead of a 4-deep queue; the engine then
// reads one slot at a time, with a read state and an evaluate state per slot:
// lookup and delete probe from the home slot, delete then backward-shifts the
// following slots, and insert first scans to the first free slot and then walks
// again from home (with no free slot it searches the window for its key).
// Clear sweeps all 2^TABLE_LOG2 slots, one per cycle. After reset the same
// sweep runs and s_tready stays low until it ends. A stalled result holds in
// the output register while new beats keep entering the queue.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_top
#(
    parameter int TABLE_LOG2 = 10,
    parameter int VALUE_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [rhh_pkg::IN_W-1:0] s_tdata,   // mode, key, value_in
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [rhh_pkg::OUT_W-1:0] m_tdata,  // status, value_out, entry_count,
                                                // load_high, slots_visited
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [31:0]              cfg_wdata
);

    logic [31:0]    hash_seed_reg;
    logic [3:0]     size_log2_reg;
    logic           clearing;
    logic           push_valid;
    logic           push_ready;
    rhh_pkg::item_t push_item;
    logic           q_valid;
    logic           q_pop;
    rhh_pkg::item_t q_item;
    rhh_pkg::res_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg <= '0;
            size_log2_reg <= 4'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rhh_pkg::REG_HASH_SEED: hash_seed_reg <= cfg_wdata;
                rhh_pkg::REG_SIZE_LOG2: size_log2_reg <= cfg_wdata[3:0];
                default:                hash_seed_reg <= hash_seed_reg;
            endcase
        end
    end

    rhh_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tdata[1:0]),
        .in_key     (s_tdata[33:2]),
        .in_value   (s_tdata[65:34]),
        .seed       (hash_seed_reg),
        .hold       (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    rhh_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    rhh_back #(.TABLE_LOG2(TABLE_LOG2), .VALUE_BITS(VALUE_BITS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .size_log2  (size_log2_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .clearing   (clearing),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {6'd0, res.visited, res.load_high, res.count, res.value, res.status};

endmodule

// ===== design/rhh_checker.sv =====
// ----------------------------------------------------------------------------
// Robin Hood hash table port checker
// Watches the result channel of the top level.
// ----------------------------------------------------------------------------
`include "robin_hood_hash_table_top_macros.svh"

module rhh_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [rhh_pkg::OUT_W-1:0] m_tdata
);

    `RHH_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RHH_ASSERT_NOW(a_status, clk, rst_n, m_tvalid, m_tdata[2:0] != 3'd7)
    `RHH_ASSERT_NOW(a_clear, clk, rst_n, m_tvalid && m_tdata[2:0] == rhh_pkg::ST_CLEARED, m_tdata[57:35] == '0)
    `RHH_ASSERT_NOW(a_value, clk, rst_n, m_tvalid && m_tdata[2:0] != rhh_pkg::ST_FOUND, m_tdata[34:3] == '0)

endmodule

bind robin_hood_hash_table_top rhh_checker u_rhh_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robin Hood hash table testbench
// Streams lookup, insert, delete and clear beats into the table under random
// burst gaps and output stalls, keeps a shadow table with its own hashing and
// probing, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb;
    import rhh_pkg::*;

    localparam int SLOT_MAX = 1024;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
    } cmd_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] value;
        logic [10:0] count;
        logic        load_high;
        logic [10:0] visited;
    } reply_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_we;
    logic cfg_index;
    logic [31:0] cfg_wdata;

    robin_hood_hash_table_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // shadow table
    logic        shadow_valid [SLOT_MAX];
    logic [31:0] shadow_key   [SLOT_MAX];
    logic [31:0] shadow_value [SLOT_MAX];
    int unsigned shadow_dist  [SLOT_MAX];
    int unsigned shadow_count;
    logic [31:0] seed_copy;
    logic [3:0]  size_copy;

    cmd_t   pending_cmds[$];
    reply_t expected_replies[$];
    cmd_t   cur_cmd;
    int     burst_left;
    int     gap_left;
    int     errors;
    int     replies_seen;
    int     hold_left;
    bit     hold_done;
    int     pattern_kind;
    int     pattern_cycles;
    int     idle_cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [31:0] key_hash(input logic [31:0] key, input logic [31:0] seed);
        logic [31:0] k;
        logic [31:0] h;
        k = key * MIX_C1;
        k = {k[16:0], k[31:17]};
        k = k * MIX_C2;
        h = seed ^ k;
        h = {h[18:0], h[31:19]};
        h = h * 32'd5 + MIX_C3;
        h = h ^ 32'd4;
        h = h ^ (h >> 16);
        h = h * MIX_C4;
        h = h ^ (h >> 13);
        h = h * MIX_C5;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic int unsigned window_bits();
        if (size_copy < 4'd3)
            return 3;
        if (size_copy > 4'd10)
            return 10;
        return size_copy;
    endfunction

    function automatic reply_t apply_table_op(input cmd_t c);
        reply_t r;
        int unsigned cap;
        int unsigned mask;
        int unsigned idx;
        int unsigned probe;
        int unsigned visited;
        int unsigned cur;
        int unsigned nxt;
        int unsigned td;
        logic [31:0] k;
        logic [31:0] v;
        logic [31:0] tk;
        logic [31:0] tv;
        bit has_empty;
        bit done;
        cap = 1 << window_bits();
        mask = cap - 1;
        idx = key_hash(c.key, seed_copy) & mask;
        probe = 0;
        visited = 0;
        done = 0;
        r.status = ST_MISSING;
        r.value = '0;
        if (c.mode == MODE_CLEAR) begin
            foreach (shadow_valid[i])
                shadow_valid[i] = 1'b0;
            shadow_count = 0;
            r.status = ST_CLEARED;
        end else if (c.mode == MODE_LOOKUP || c.mode == MODE_DELETE) begin
            for (int i = 0; i < cap && !done; i++) begin
                visited++;
                if (!shadow_valid[idx]) begin
                    done = 1;
                end else if (shadow_key[idx] == c.key) begin
                    done = 1;
                    if (c.mode == MODE_LOOKUP) begin
                        r.status = ST_FOUND;
                        r.value = shadow_value[idx];
                    end else begin
                        cur = idx;
                        nxt = (idx + 1) & mask;
                        for (int m = 0; m + 1 < cap; m++) begin
                            if (!shadow_valid[nxt] || shadow_dist[nxt] == 0)
                                break;
                            shadow_key[cur] = shadow_key[nxt];
                            shadow_value[cur] = shadow_value[nxt];
                            shadow_dist[cur] = shadow_dist[nxt] - 1;
                            cur = nxt;
                            nxt = (nxt + 1) & mask;
                        end
                        shadow_valid[cur] = 1'b0;
                        if (shadow_count > 0)
                            shadow_count--;
                        r.status = ST_DELETED;
                    end
                end else if (shadow_dist[idx] < probe) begin
                    done = 1;
                end else begin
                    idx = (idx + 1) & mask;
                    probe++;
                end
            end
        end else begin
            has_empty = 0;
            for (int i = 0; i < cap; i++)
                if (!shadow_valid[i])
                    has_empty = 1;
            r.status = ST_FULL;
            k = c.key;
            v = c.value;
            for (int i = 0; i < cap && !done; i++) begin
                visited++;
                if (!has_empty) begin
                    if (shadow_key[idx] == k) begin
                        shadow_value[idx] = v;
                        r.status = ST_REPLACED;
                        done = 1;
                    end
                end else if (!shadow_valid[idx]) begin
                    shadow_valid[idx] = 1'b1;
                    shadow_key[idx] = k;
                    shadow_value[idx] = v;
                    shadow_dist[idx] = probe;
                    if (shadow_count < SLOT_MAX)
                        shadow_count++;
                    r.status = ST_INSERTED;
                    done = 1;
                end else if (shadow_key[idx] == k) begin
                    shadow_value[idx] = v;
                    r.status = ST_REPLACED;
                    done = 1;
                end else if (probe > shadow_dist[idx]) begin
                    tk = shadow_key[idx];
                    tv = shadow_value[idx];
                    td = shadow_dist[idx];
                    shadow_key[idx] = k;
                    shadow_value[idx] = v;
                    shadow_dist[idx] = probe;
                    k = tk;
                    v = tv;
                    probe = td;
                end
                if (!done) begin
                    idx = (idx + 1) & mask;
                    probe++;
                end
            end
        end
        r.count = shadow_count[10:0];
        r.load_high = (shadow_count >= (cap * 2) / 3);
        r.visited = visited[10:0];
        return r;
    endfunction

    task automatic push_cmd(input logic [1:0] mode, input logic [31:0] key,
                            input logic [31:0] value);
        cmd_t c;
        c.mode = mode;
        c.key = key;
        c.value = value;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_tvalid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == REG_HASH_SEED)
            seed_copy = data;
        else
            size_copy = data[3:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int count, input bit start_clear);
        logic [31:0] key_pool[$];
        int pool_n;
        int roll;
        logic [31:0] key;
        pool_n = (1 << window_bits()) + (1 << window_bits()) / 2;
        if (pool_n > 48)
            pool_n = 48;
        for (int i = 0; i < pool_n; i++)
            key_pool.push_back($urandom);
        if (start_clear)
            push_cmd(MODE_CLEAR, $urandom, $urandom);
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            key = ($urandom_range(0, 9) == 0) ? $urandom
                                               : key_pool[$urandom_range(0, pool_n - 1)];
            if (roll < 45)
                push_cmd(MODE_INSERT, key, $urandom);
            else if (roll < 72)
                push_cmd(MODE_LOOKUP, key, $urandom);
            else if (roll < 98)
                push_cmd(MODE_DELETE, key, $urandom);
            else
                push_cmd(MODE_CLEAR, key, $urandom);
        end
    endtask

    // sender: bursts with random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_table_op(cur_cmd));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd <= pending_cmds[0];
                    s_tdata <= {6'd0, pending_cmds[0].value, pending_cmds[0].key,
                                pending_cmds[0].mode};
                    void'(pending_cmds.pop_front());
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern, one long hold-off, result check
    always @(posedge clk or negedge rst_n) begin
        reply_t got;
        reply_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
            replies_seen = 0;
            hold_left = 0;
            hold_done = 0;
            pattern_kind = 0;
            pattern_cycles = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[2:0];
                got.value = m_tdata[34:3];
                got.count = m_tdata[45:35];
                got.load_high = m_tdata[46];
                got.visited = m_tdata[57:47];
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected beat status=%0d value=%h count=%0d", $time,
                             got.status, got.value, got.count);
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        errors++;
                    end
                    if (got.value !== want.value) begin
                        $display("%0t: value_out expected %h actual %h", $time,
                                 want.value, got.value);
                        errors++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: entry_count expected %0d actual %0d", $time,
                                 want.count, got.count);
                        errors++;
                    end
                    if (got.load_high !== want.load_high) begin
                        $display("%0t: load_high expected %0d actual %0d", $time,
                                 want.load_high, got.load_high);
                        errors++;
                    end
                    if (got.visited !== want.visited) begin
                        $display("%0t: slots_visited expected %0d actual %0d", $time,
                                 want.visited, got.visited);
                        errors++;
                    end
                end
            end
            if (!hold_done && replies_seen == 120) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (pattern_cycles == 0) begin
                pattern_kind = $urandom_range(0, 2);
                pattern_cycles = $urandom_range(20, 120);
            end else begin
                pattern_cycles--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (pattern_kind == 0) begin
                m_tready <= 1'b1;
            end else if (pattern_kind == 1) begin
                m_tready <= $urandom_range(0, 1);
            end else begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("robin_hood_hash_table_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] full_keys[$];
        errors = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        seed_copy = '0;
        size_copy = 4'd3;
        foreach (shadow_valid[i])
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_value[i] = '0;
            shadow_dist[i] = 0;
        end
        shadow_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, replace, delete, miss, full window, clear
        write_reg(REG_HASH_SEED, 32'h0);
        write_reg(REG_SIZE_LOG2, 32'd3);
        push_cmd(MODE_LOOKUP, 32'h0, 32'h0);
        push_cmd(MODE_INSERT, 32'h0, 32'hffffffff);
        push_cmd(MODE_INSERT, 32'hffffffff, 32'h0);
        push_cmd(MODE_LOOKUP, 32'h0, 32'h0);
        push_cmd(MODE_LOOKUP, 32'hffffffff, 32'hffffffff);
        push_cmd(MODE_INSERT, 32'h0, 32'h5a5aa5a5);
        push_cmd(MODE_DELETE, 32'h12345678, 32'h0);
        push_cmd(MODE_DELETE, 32'h0, 32'hffffffff);
        push_cmd(MODE_LOOKUP, 32'h0, 32'h0);
        for (int i = 0; i < 8; i++)
            full_keys.push_back($urandom);
        foreach (full_keys[i])
            push_cmd(MODE_INSERT, full_keys[i], $urandom);
        push_cmd(MODE_INSERT, full_keys[3], 32'hdeadbeef);
        push_cmd(MODE_INSERT, 32'h0badf00d, $urandom);
        push_cmd(MODE_LOOKUP, full_keys[3], 32'h0);
        push_cmd(MODE_DELETE, full_keys[5], 32'h0);
        push_cmd(MODE_LOOKUP, 32'h0badf00d, 32'h0);
        push_cmd(MODE_CLEAR, 32'hffffffff, 32'hffffffff);
        push_cmd(MODE_LOOKUP, full_keys[0], 32'h0);
        wait_drained();

        write_reg(REG_HASH_SEED, $urandom);
        write_reg(REG_SIZE_LOG2, 32'd4);
        random_phase(220, 1);
        wait_drained();
        write_reg(REG_HASH_SEED, 32'hffffffff);
        write_reg(REG_SIZE_LOG2, 32'd3);
        random_phase(220, 1);
        wait_drained();
        write_reg(REG_HASH_SEED, $urandom);
        write_reg(REG_SIZE_LOG2, 32'd10);
        random_phase(200, 1);
        wait_drained();
        write_reg(REG_HASH_SEED, $urandom);
        write_reg(REG_SIZE_LOG2, 32'd0);
        random_phase(220, 1);
        wait_drained();
        write_reg(REG_HASH_SEED, $urandom);
        write_reg(REG_SIZE_LOG2, 32'd15);
        random_phase(160, 1);
        wait_drained();
        write_reg(REG_HASH_SEED, $urandom);
        write_reg(REG_SIZE_LOG2, 32'd5);
        random_phase(220, 1);
        wait_drained();
        // shrink without clear
        write_reg(REG_SIZE_LOG2, 32'd4);
        random_phase(120, 0);
        wait_drained();
        write_reg(REG_HASH_SEED, $urandom);
        write_reg(REG_SIZE_LOG2, 32'd2);
        random_phase(220, 1);
        wait_drained();
        write_reg(REG_SIZE_LOG2, 32'd6);
        random_phase(200, 1);
        wait_drained();
        repeat (50) @(posedge clk);

        if (errors == 0)
            $display("robin_hood_hash_table_top regression: pass");
        else
            $display("robin_hood_hash_table_top regression: fail");
        $finish;
    end
endmodule
